[sv/sobel_edge_magnitude_rgb_macros.svh]
// assertion macros for the sobel edge magnitude block
// needs i_clk and i_rst_n in the scope of each use
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// same-cycle implication, checked out of reset only
`define SEM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sobel edge magnitude assertion failed");

// next-cycle implication, checked out of reset only
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sobel edge magnitude assertion failed");

`endif

[sv/sem_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the sobel edge magnitude block
// no dependencies
package sem_pkg;

    localparam int PIX_W = 8;
    localparam int RGB_W = 3 * PIX_W;
    localparam int CFG_W = 13;
    localparam int LANES = 3;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [RGB_W-1:0] t_rgb;
    typedef logic [PIX_W-1:0] t_pix;

    // status a lane hands to the merge stage
    typedef struct packed {
        logic done;
        t_pix mag;
    } t_lane_stat;

endpackage

[sv/sem_line_store.sv]
`timescale 1ns / 1ps
// one line store: single write port, registered read port
// uses sem_pkg
module sem_line_store
    import sem_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_rgb                     i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_rgb                     o_rdata
);

    t_rgb r_mem [DEPTH];
    t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sem_lane.sv]
`timescale 1ns / 1ps
// one color lane: sobel gradients, sum of squares, rounded iterative root
// uses sem_pkg
module sem_lane
    import sem_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_pix       i_pix [3][3],
    output t_lane_stat o_stat
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_SQ   = 4'b0010,
        L_ROOT = 4'b0100,
        L_FIN  = 4'b1000
    } t_lstate;

    t_lstate            r_state;
    logic               r_done;
    logic signed [10:0] r_gx, r_gy;
    logic [20:0]        r_s;
    logic [8:0]         r_n;
    logic [3:0]         r_bit;
    t_pix               r_mag;

    logic signed [10:0] n_gx, n_gy;
    logic signed [21:0] w_sqx, w_sqy;
    logic [21:0]        w_sum;
    logic [8:0]         w_t;
    logic [17:0]        w_tt;
    logic [18:0]        w_nn;
    logic [9:0]         w_up;

    function automatic logic signed [10:0] sx(input t_pix p);
        sx = signed'({3'b000, p});
    endfunction

    always_comb begin
        n_gx = (sx(i_pix[0][2]) + (sx(i_pix[1][2]) <<< 1) + sx(i_pix[2][2]))
             - (sx(i_pix[0][0]) + (sx(i_pix[1][0]) <<< 1) + sx(i_pix[2][0]));
        n_gy = (sx(i_pix[2][0]) + (sx(i_pix[2][1]) <<< 1) + sx(i_pix[2][2]))
             - (sx(i_pix[0][0]) + (sx(i_pix[0][1]) <<< 1) + sx(i_pix[0][2]));
        w_sqx = r_gx * r_gx;
        w_sqy = r_gy * r_gy;
        w_sum = unsigned'(w_sqx) + unsigned'(w_sqy);
        w_t   = r_n | (9'd1 << r_bit);
        w_tt  = w_t * w_t;
        w_nn  = 19'(r_n) * 19'(r_n) + 19'(r_n);
        w_up  = (r_s > {2'b00, w_nn}) ? 10'(r_n) + 10'd1 : 10'(r_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_done  <= 1'b0;
                        r_state <= L_SQ;
                    end
                end
                L_SQ: r_state <= L_ROOT;
                L_ROOT: begin
                    if (r_bit == 4'd0) begin
                        r_state <= L_FIN;
                    end
                end
                L_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_gx <= n_gx;
                r_gy <= n_gy;
            end
            L_SQ: begin
                r_s   <= w_sum[20:0];
                r_n   <= 9'd0;
                r_bit <= 4'd8;
            end
            L_ROOT: begin
                if ({3'b000, w_tt} <= r_s) begin
                    r_n <= w_t;
                end
                r_bit <= r_bit - 4'd1;
            end
            L_FIN: r_mag <= (w_up > 10'd255) ? 8'd255 : w_up[7:0];
            default: ;
        endcase
    end

    assign o_stat.done = r_done;
    assign o_stat.mag  = r_mag;

endmodule

[sv/sobel_edge_magnitude_rgb.sv]
`timescale 1ns / 1ps
// top level of the rgb sobel edge magnitude block: counters, line stores, window, merge
// uses sem_pkg, sem_line_store, sem_lane and the macros header
//
// Takes rgb pixels in raster order and returns, per channel, round(sqrt(gx^2+gy^2))
// saturated at 255, with neighbors outside the frame taken as zero. Results lag by one
// line plus one pixel, so after each frame send width+1 flush transactions
// (tuser=1) to push out the last results; m_axis_tlast marks the frame's final pixel.
// A flush before the frame is complete is dropped, a pixel after it acts as a flush.
// A transaction without a result passes only through S_READ; one with a result also
// runs S_CALC and S_WAIT, where the three color lanes run their nine-step square roots
// in parallel. The next input is taken while a finished result waits on m_axis.
// Configuration writes restart the frame count and are meant for idle periods.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: index 0 image_width, index 1 image_height
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic             s_axis_tuser,   // action: 0 pixel, 1 flush
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // red_edge [7:0], green_edge [15:8], blue_edge [23:16]
    output logic             m_axis_tlast    // frame_last
);

    `include "sobel_edge_magnitude_rgb_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state        r_state;
    logic [WW-1:0] r_w;
    logic [RW-1:0] r_h;
    logic [CW-1:0] r_col, r_acol, r_qc;
    logic [RW-1:0] r_row, r_qr;
    t_rgb          r_sample;
    logic          r_emit, r_last;
    logic [2:0]    r_rows, r_cols;
    t_rgb          r_win [3][3];
    logic          r_otvalid, r_olast;
    t_rgb          r_odata;

    logic          w_accept, w_in_frame, w_flush, w_drop, w_pos_ok, w_q_ok;
    logic          w_emit, w_last, w_col_wrap;
    logic [2:0]    w_done_vec;
    logic          w_out_free;
    t_rgb          w_up_rd, w_mid_rd;
    t_pix          w_lane_pix [LANES][3][3];
    t_lane_stat    w_stat [LANES];
    logic [31:0]   w_wcfg, w_hcfg;

    // input side decode
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_flush    = s_axis_tuser;
    assign w_in_frame = (r_row < r_h);
    assign w_drop     = w_flush && w_in_frame;
    // position has reached width+1
    assign w_pos_ok   = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (r_col != '0));
    assign w_q_ok     = (r_qr < r_h);
    assign w_emit     = w_pos_ok && w_q_ok;
    assign w_last     = (r_qr + RW'(1) == r_h) && (WW'(r_qc) + WW'(1) == r_w);
    assign w_col_wrap = (WW'(r_col) + WW'(1) >= r_w);

    // clamp configuration values to the supported range
    assign w_wcfg = {21'd0, i_cfg_data[10:0]};
    assign w_hcfg = {19'd0, i_cfg_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_w     <= WW'(W_RST);
            r_h     <= RW'(H_RST);
            r_col   <= '0;
            r_row   <= '0;
            r_qc    <= '0;
            r_qr    <= '0;
            r_emit  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // any write restarts the frame
                r_col <= '0;
                r_row <= '0;
                r_qc  <= '0;
                r_qr  <= '0;
                if (i_cfg_index == REG_WIDTH) begin
                    if (w_wcfg == 32'd0) begin
                        r_w <= WW'(1);
                    end else if (w_wcfg > 32'(MAX_WIDTH)) begin
                        r_w <= WW'(MAX_WIDTH);
                    end else begin
                        r_w <= WW'(w_wcfg);
                    end
                end else begin
                    if (w_hcfg == 32'd0) begin
                        r_h <= RW'(1);
                    end else if (w_hcfg > 32'(MAX_HEIGHT)) begin
                        r_h <= RW'(MAX_HEIGHT);
                    end else begin
                        r_h <= RW'(w_hcfg);
                    end
                end
            end else if (w_accept && !w_drop) begin
                r_emit <= w_emit;
                if (w_emit && w_last) begin
                    // final result of the frame: next transaction starts a new one
                    r_col <= '0;
                    r_row <= '0;
                    r_qc  <= '0;
                    r_qr  <= '0;
                end else begin
                    if (w_col_wrap) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                    if (w_emit) begin
                        if (WW'(r_qc) + WW'(1) == r_w) begin
                            r_qc <= '0;
                            r_qr <= r_qr + RW'(1);
                        end else begin
                            r_qc <= r_qc + CW'(1);
                        end
                    end
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && !w_drop) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= r_emit ? S_CALC : S_IDLE;
                S_CALC: r_state <= S_WAIT;
                S_WAIT: begin
                    if ((&w_done_vec) && w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload captured with the transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acol   <= r_col;
            r_sample <= (w_in_frame && !w_flush) ? s_axis_tdata : '0;
            r_last   <= w_last;
            r_rows   <= {(r_qr + RW'(1) < r_h), 1'b1, (r_qr != '0)};
            r_cols   <= {(WW'(r_qc) + WW'(1) < r_w), 1'b1, (r_qc != '0)};
        end
    end

    // window shift once the line store data is back
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= w_up_rd;
            r_win[1][2] <= w_mid_rd;
            r_win[2][2] <= r_sample;
        end
    end

    sem_line_store #(.DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_acol),
        .i_wdata (w_mid_rd),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_up_rd)
    );

    sem_line_store #(.DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_acol),
        .i_wdata (r_sample),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_mid_rd)
    );

    // lanes see the window with out-of-frame neighbors forced to zero
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    w_lane_pix[k][i][j] = (r_rows[i] && r_cols[j]) ?
                                          r_win[i][j][k*PIX_W +: PIX_W] : '0;
                end
            end
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        sem_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_state == S_CALC),
            .i_pix   (w_lane_pix[k]),
            .o_stat  (w_stat[k])
        );
        assign w_done_vec[k] = w_stat[k].done;
    end

    // merge stage: output register, freed when the consumer takes it
    assign w_out_free = !r_otvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otvalid <= 1'b0;
        end else if ((r_state == S_WAIT) && (&w_done_vec) && w_out_free) begin
            r_otvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_otvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WAIT) && (&w_done_vec) && w_out_free) begin
            r_odata <= {w_stat[2].mag, w_stat[1].mag, w_stat[0].mag};
            r_olast <= r_last;
        end
    end

    assign m_axis_tvalid = r_otvalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    `SEM_ASSERT_IMPL(a_col_in_range, 1'b1, WW'(r_col) < r_w)
    `SEM_ASSERT_IMPL(a_qrow_in_range, 1'b1, r_qr < r_h)
    `SEM_ASSERT_IMPL(a_lanes_in_step, 1'b1, (w_done_vec == 3'b000) || (w_done_vec == 3'b111))
    `SEM_ASSERT_NEXT(a_start_clears_done, r_state == S_CALC, w_done_vec == 3'b000)

endmodule

[bench/sobel_edge_magnitude_rgb_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for the rgb sobel edge magnitude block
// uses sem_pkg and the top level sobel_edge_magnitude_rgb
module sobel_edge_magnitude_rgb_tb;
    import sem_pkg::*;

    localparam int LINE_MAX  = 1024;
    localparam int ROWS_MAX  = 4096;
    localparam int SETTLE    = 40;     // cycles a no-result transaction may still be in flight
    localparam int RAND_GOAL = 1350;
    localparam int HOLD_LEN  = 400;
    localparam int CUT_CAP   = 150;    // most pixels sent into a frame that is cut short

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit       last;
    } edge_t;

    typedef enum bit [1:0] { ROW_SET_W, ROW_SET_H, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t kind;
        bit        flush;
        bit [12:0] r;      // also the register value on set rows
        bit [7:0]  g;
        bit [7:0]  b;
        bit        typed;
        bit [7:0]  er;
        bit [7:0]  eg;
        bit [7:0]  eb;
        bit        el;
    } row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata;   // red_in [7:0], green_in [15:8], blue_in [23:16]
    logic             s_axis_tuser;   // action: 0 pixel, 1 flush
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [23:0]      m_axis_tdata;   // red_edge [7:0], green_edge [15:8], blue_edge [23:16]
    logic             m_axis_tlast;   // frame_last

    sobel_edge_magnitude_rgb dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // mirror of the block state
    bit [23:0]   line_up  [LINE_MAX];
    bit [23:0]   line_mid [LINE_MAX];
    bit [23:0]   win [3][3];
    int unsigned in_col, in_row, emitted;
    int unsigned width_reg, height_reg;

    edge_t       edge_q[$];       // expected edge results, oldest first
    int          errors;
    int          n_items;         // accepted input transactions
    int          n_results;       // checked output transactions
    int          n_frames;
    bit          quiet;           // no idling on either side while set
    bit          hold_now;        // asks the receiver for one long stall

    // typed expectation riding with the transaction on the bus
    bit          cur_typed;
    edge_t       cur_exp;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > ROWS_MAX) return ROWS_MAX;
        return height_reg;
    endfunction

    // nearest integer root, saturated at 255
    function automatic bit [7:0] root_sat(int unsigned s);
        int unsigned n;
        int unsigned t;
        n = 0;
        if (s >= 255 * 255 + 256) return 8'd255;
        for (int k = 8; k >= 0; k--) begin
            t = n | (1 << k);
            if (t * t <= s) n = t;
        end
        if (s > n * n + n) n++;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function automatic bit [7:0] channel_mag(int sh, bit ok [3][3]);
        int gx, gy, v;
        int kx [3][3];
        int ky [3][3];
        kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
        ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
        gx = 0;
        gy = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (ok[i][j]) begin
                    v = (win[i][j] >> sh) & 8'hff;
                    gx += v * kx[i][j];
                    gy += v * ky[i][j];
                end
        return root_sat(gx * gx + gy * gy);
    endfunction

    // advances the mirror by one accepted transaction; returns 1 when it yields a result
    function automatic bit edge_step(bit flush, bit [23:0] bus, output edge_t o);
        int unsigned w, h, total, pos, c, q, r, qc;
        bit [23:0] px;
        bit ok [3][3];
        bit rows [3];
        bit cols [3];
        w = eff_width();
        h = eff_height();
        total = w * h;
        pos = in_row * w + in_col;
        c = in_col;
        px = 24'd0;
        o = '{default: 0};
        if (flush && pos < total) return 0;   // early flush is dropped
        if (!flush && pos < total) px = {bus[7:0], bus[15:8], bus[23:16]};
        if (c >= LINE_MAX) c = LINE_MAX - 1;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_up[c];
        win[1][2] = line_mid[c];
        win[2][2] = px;
        line_up[c] = line_mid[c];
        line_mid[c] = px;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (pos >= w + 1 && emitted < total) begin
            q = emitted;
            r = q / w;
            qc = q % w;
            rows = '{r >= 1, 1'b1, r + 1 < h};
            cols = '{qc >= 1, 1'b1, qc + 1 < w};
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    ok[i][j] = rows[i] && cols[j];
            o.red = channel_mag(16, ok);
            o.green = channel_mag(8, ok);
            o.blue = channel_mag(0, ok);
            emitted++;
            if (q + 1 == total) begin
                o.last = 1'b1;
                in_col = 0;
                in_row = 0;
                emitted = 0;
            end
            return 1;
        end
        return 0;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // prediction on every accepted input, checking on every accepted output
    always @(posedge i_clk) begin
        edge_t p;
        edge_t e;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            n_items++;
            if (edge_step(s_axis_tuser, s_axis_tdata, p))
                edge_q.push_back(cur_typed ? cur_exp : p);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (edge_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = edge_q.pop_front();
                if (m_axis_tdata[7:0] !== e.red)
                    report_mismatch($sformatf("red %0d want %0d", m_axis_tdata[7:0], e.red));
                if (m_axis_tdata[15:8] !== e.green)
                    report_mismatch($sformatf("green %0d want %0d", m_axis_tdata[15:8], e.green));
                if (m_axis_tdata[23:16] !== e.blue)
                    report_mismatch($sformatf("blue %0d want %0d", m_axis_tdata[23:16], e.blue));
                if (m_axis_tlast !== e.last)
                    report_mismatch($sformatf("tlast %0b want %0b", m_axis_tlast, e.last));
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int k;
        if (quiet) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // receiver: random back-pressure plus one long stall on request
    initial begin
        int g;
        m_axis_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_now) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_now = 1'b0;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // one input transaction, held until accepted, then an optional gap
    task automatic send_item(bit flush, bit [7:0] r, bit [7:0] g, bit [7:0] b,
                             bit typed = 0, edge_t e = '{default: 0});
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= flush;
        s_axis_tdata  <= {b, g, r};
        cur_typed     <= typed;
        cur_exp       <= e;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drains all expected results, then lets trailing no-result work settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (edge_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_WIDTH) width_reg = val & 11'h7ff;
        else height_reg = val & 13'h1fff;
        in_col = 0;
        in_row = 0;
        emitted = 0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // one frame with random content; style picks the sample mix
    task automatic run_frame(bit cut_short);
        int unsigned n;
        int unsigned stop;
        int style;
        bit [7:0] c [3];
        n = eff_width() * eff_height();
        style = $urandom_range(0, 9);
        stop = cut_short ? $urandom_range(1, (n < CUT_CAP) ? n : CUT_CAP) : n;
        for (int unsigned p = 0; p < stop; p++) begin
            if ($urandom_range(0, 19) == 0)   // early flush, dropped
                send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            for (int k = 0; k < 3; k++) begin
                if (style < 6) c[k] = 8'($urandom);
                else if (style < 9) c[k] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                else c[k] = 8'h80;
            end
            send_item(1'b0, c[0], c[1], c[2]);
        end
        if (cut_short) return;
        for (int unsigned p = 0; p <= eff_width(); p++) begin
            // a late pixel acts as a flush
            if ($urandom_range(0, 4) == 0)
                send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        n_frames++;
    endtask

    row_t dir_tab [] = '{
        '{ROW_SET_W, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SET_H, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  1, 9, 9, 9, 0, 0, 0, 0, 0},                   // early flush
        '{ROW_ITEM,  0, 255, 255, 255, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  0, 0, 128, 7, 0, 0, 0, 0, 0},                 // late pixel
        '{ROW_ITEM,  1, 0, 0, 0, 1, 0, 0, 0, 1},
        '{ROW_ITEM,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  1, 0, 0, 0, 1, 0, 0, 0, 1},
        '{ROW_SET_W, 0, 2, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SET_H, 0, 2, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  0, 255, 0, 255, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  0, 0, 255, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  0, 0, 0, 255, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  0, 255, 255, 255, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_SET_W, 0, 0, 0, 0, 0, 0, 0, 0, 0},                  // zero acts as one
        '{ROW_SET_H, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  0, 1, 2, 3, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM,  1, 0, 0, 0, 1, 0, 0, 0, 1}
    };

    initial begin
        int unsigned w, h;
        int rand_start;
        edge_t e;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_frames = 0;
        quiet = 1'b0;
        hold_now = 1'b0;
        width_reg = 1024;
        height_reg = 1024;
        in_col = 0;
        in_row = 0;
        emitted = 0;
        foreach (line_up[k]) begin
            line_up[k] = 0;
            line_mid[k] = 0;
        end
        foreach (win[i, j]) win[i][j] = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cur_typed     <= 1'b0;
        cur_exp       <= '{default: 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_SET_W || dir_tab[k].kind == ROW_SET_H) begin
                wait_drained();
                write_reg(dir_tab[k].kind == ROW_SET_W ? REG_WIDTH : REG_HEIGHT, dir_tab[k].r);
            end else begin
                e = '{dir_tab[k].er, dir_tab[k].eg, dir_tab[k].eb, dir_tab[k].el};
                send_item(dir_tab[k].flush, dir_tab[k].r[7:0], dir_tab[k].g, dir_tab[k].b,
                          dir_tab[k].typed, e);
            end
        end

        // random frames, mostly small
        rand_start = n_items;
        while (n_items - rand_start < RAND_GOAL) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            quiet = ($urandom_range(0, 5) == 0);
            set_frame(w, h);
            if (n_frames == 6) begin
                // long receiver stall while the sender keeps pushing
                set_frame(32, 4);
                hold_now = 1'b1;
            end
            run_frame($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 7) == 0) wait_drained();   // sender waits for all results
        end

        // register extremes, each frame cut short
        quiet = 1'b0;
        set_frame(1024, 1);
        run_frame(1'b1);
        set_frame(2047, 1);
        run_frame(1'b1);
        set_frame(1, 4096);
        run_frame(1'b1);
        set_frame(3, 8191);
        run_frame(1'b1);
        set_frame(1, 8191);
        run_frame(1'b1);

        wait_drained();
        $display("covered %0d input and %0d output transactions over %0d frames",
                 n_items, n_results, n_frames);
        $display("sizes from one pixel up to the width and height limits, with stalls");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/sem_pkg.sv
sv/sem_line_store.sv
sv/sem_lane.sv
sv/sobel_edge_magnitude_rgb.sv
bench/sobel_edge_magnitude_rgb_tb.sv
